### hdl/fiht_pkg.sv
// Shared types and constants for the frame index hash table.
// Used by fiht_ctrl, fiht_dp and frame_index_hash_table; no dependencies.
`timescale 1ns / 1ps

package fiht_pkg;

   localparam int FRAME_W = 14;
   localparam int KEY_W   = 32;

   localparam logic [1:0] OP_ASSIGN = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_FETCH  = 2'd2;

   localparam logic [KEY_W-1:0] HASH_MULT = 32'd383;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_G_KEY,
      ST_G_SLOT,
      ST_A_KRD,
      ST_A_KCHK,
      ST_C_KEY,
      ST_C_SRD,
      ST_C_SWR,
      ST_P_RD,
      ST_P_CHK,
      ST_L_GRP,
      ST_L_SRD,
      ST_L_SCHK,
      ST_L_KCHK,
      ST_L_NEXT,
      ST_F_DATA,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic req_load;
      logic alloc_frame;
      logic alloc_max;
      logic kinit_grp;
      logic kinit_clean;
      logic k_step;
      logic sinit_frame;
      logic sinit_max;
      logic s_clr_wr;
      logic s_rd;
      logic s_cond_wr;
      logic s_step;
      logic key_rd_frame;
      logic probe_init;
      logic probe_rd;
      logic probe_adv;
      logic assign_wr;
      logic lk_init;
      logic lk_grp_init;
      logic lk_hit_rd;
      logic lk_chk;
      logic lk_dec;
      logic set_err;
      logic fetch_latch;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       clr_done;
      logic       frame_ok;
      logic       frame_first;
      logic       fetch_ok;
      logic       key_nz;
      logic       clean_ok;
      logic       clean_keys_empty;
      logic       kdone;
      logic       sdone;
      logic       slot_zero;
      logic       left_zero;
      logic       maxf_zero;
      logic       grp_active;
      logic       lk_stop;
   } stat_type;

endpackage

### hdl/fiht_ctrl.sv
// Sequencer for the frame index hash table: clear pass, assign, lookup, fetch.
// Depends on fiht_pkg; drives fiht_dp through cmd_type, reads stat_type.
`timescale 1ns / 1ps

module fiht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   input  fiht_pkg::stat_type stat,
   output fiht_pkg::cmd_type  cmd
);

   fiht_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == fiht_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fiht_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fiht_pkg::ST_CLEAR: begin
            if (stat.clr_done) state_in = fiht_pkg::ST_IDLE;
         end
         fiht_pkg::ST_IDLE: begin
            if (req_valid) state_in = fiht_pkg::ST_DISPATCH;
         end
         fiht_pkg::ST_DISPATCH: begin
            state_in = fiht_pkg::ST_DONE;
            if (stat.op == fiht_pkg::OP_ASSIGN) begin
               if (stat.frame_ok) begin
                  state_in = stat.frame_first ? fiht_pkg::ST_G_KEY : fiht_pkg::ST_A_KRD;
               end
            end else if (stat.op == fiht_pkg::OP_LOOKUP) begin
               if (!stat.maxf_zero) state_in = fiht_pkg::ST_L_GRP;
            end else if (stat.op == fiht_pkg::OP_FETCH) begin
               if (stat.fetch_ok) state_in = fiht_pkg::ST_F_DATA;
            end
         end
         fiht_pkg::ST_G_KEY: begin
            if (stat.kdone) state_in = fiht_pkg::ST_G_SLOT;
         end
         fiht_pkg::ST_G_SLOT: begin
            if (stat.sdone) state_in = fiht_pkg::ST_A_KRD;
         end
         fiht_pkg::ST_A_KRD: state_in = fiht_pkg::ST_A_KCHK;
         fiht_pkg::ST_A_KCHK: begin
            if (stat.key_nz && stat.clean_ok) begin
               state_in = stat.clean_keys_empty ? fiht_pkg::ST_C_SRD : fiht_pkg::ST_C_KEY;
            end else begin
               state_in = fiht_pkg::ST_P_RD;
            end
         end
         fiht_pkg::ST_C_KEY: begin
            if (stat.kdone) state_in = fiht_pkg::ST_C_SRD;
         end
         fiht_pkg::ST_C_SRD: state_in = fiht_pkg::ST_C_SWR;
         fiht_pkg::ST_C_SWR: begin
            state_in = stat.sdone ? fiht_pkg::ST_P_RD : fiht_pkg::ST_C_SRD;
         end
         fiht_pkg::ST_P_RD: state_in = fiht_pkg::ST_P_CHK;
         fiht_pkg::ST_P_CHK: begin
            if (stat.slot_zero || stat.left_zero) state_in = fiht_pkg::ST_DONE;
            else state_in = fiht_pkg::ST_P_RD;
         end
         fiht_pkg::ST_L_GRP: begin
            state_in = stat.grp_active ? fiht_pkg::ST_L_SRD : fiht_pkg::ST_L_NEXT;
         end
         fiht_pkg::ST_L_SRD: state_in = fiht_pkg::ST_L_SCHK;
         fiht_pkg::ST_L_SCHK: begin
            if (stat.slot_zero) state_in = fiht_pkg::ST_L_NEXT;
            else if (stat.left_zero) state_in = fiht_pkg::ST_DONE;
            else state_in = fiht_pkg::ST_L_KCHK;
         end
         fiht_pkg::ST_L_KCHK: state_in = fiht_pkg::ST_L_SRD;
         fiht_pkg::ST_L_NEXT: begin
            state_in = stat.lk_stop ? fiht_pkg::ST_DONE : fiht_pkg::ST_L_GRP;
         end
         fiht_pkg::ST_F_DATA: state_in = fiht_pkg::ST_DONE;
         fiht_pkg::ST_DONE: begin
            if (rsp_free) state_in = fiht_pkg::ST_IDLE;
         end
         default: state_in = fiht_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         fiht_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
         fiht_pkg::ST_IDLE: cmd.req_load = req_valid;
         fiht_pkg::ST_DISPATCH: begin
            if (stat.op == fiht_pkg::OP_ASSIGN && stat.frame_ok) begin
               cmd.alloc_frame = 1'b1;
               if (stat.frame_first) begin
                  cmd.kinit_grp   = 1'b1;
                  cmd.sinit_frame = 1'b1;
               end
            end else if (stat.op == fiht_pkg::OP_LOOKUP && !stat.maxf_zero) begin
               cmd.lk_init = 1'b1;
            end else if (stat.op == fiht_pkg::OP_FETCH && stat.fetch_ok) begin
               cmd.key_rd_frame = 1'b1;
            end
         end
         fiht_pkg::ST_G_KEY: cmd.k_step = 1'b1;
         fiht_pkg::ST_G_SLOT: begin
            cmd.s_clr_wr = 1'b1;
            cmd.s_step   = 1'b1;
         end
         fiht_pkg::ST_A_KRD: cmd.key_rd_frame = 1'b1;
         fiht_pkg::ST_A_KCHK: begin
            if (stat.key_nz && stat.clean_ok) begin
               cmd.alloc_max   = 1'b1;
               cmd.sinit_max   = 1'b1;
               cmd.kinit_clean = !stat.clean_keys_empty;
            end else begin
               cmd.probe_init = 1'b1;
            end
         end
         fiht_pkg::ST_C_KEY: cmd.k_step = 1'b1;
         fiht_pkg::ST_C_SRD: cmd.s_rd = 1'b1;
         fiht_pkg::ST_C_SWR: begin
            cmd.s_cond_wr  = 1'b1;
            cmd.s_step     = 1'b1;
            cmd.probe_init = stat.sdone;
         end
         fiht_pkg::ST_P_RD: cmd.probe_rd = 1'b1;
         fiht_pkg::ST_P_CHK: begin
            if (stat.slot_zero) cmd.assign_wr = 1'b1;
            else if (stat.left_zero) cmd.set_err = 1'b1;
            else cmd.probe_adv = 1'b1;
         end
         fiht_pkg::ST_L_GRP: cmd.lk_grp_init = stat.grp_active;
         fiht_pkg::ST_L_SRD: cmd.probe_rd = 1'b1;
         fiht_pkg::ST_L_SCHK: begin
            if (!stat.slot_zero) begin
               if (stat.left_zero) cmd.set_err = 1'b1;
               else cmd.lk_hit_rd = 1'b1;
            end
         end
         fiht_pkg::ST_L_KCHK: cmd.lk_chk = 1'b1;
         fiht_pkg::ST_L_NEXT: cmd.lk_dec = !stat.lk_stop;
         fiht_pkg::ST_F_DATA: cmd.fetch_latch = 1'b1;
         fiht_pkg::ST_DONE: cmd.rsp_load = rsp_free;
         default: cmd = '0;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fiht_pkg::ST_DONE && rsp_free) |=>
         (state_ff == fiht_pkg::ST_IDLE && rsp_valid_ff))
      else $error("result not posted on leaving done");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == fiht_pkg::ST_DONE))
      else $error("result posted outside done");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fiht_pkg::ST_P_CHK) |-> $past(state_ff == fiht_pkg::ST_P_RD))
      else $error("probe check without slot read");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fiht_pkg::ST_L_KCHK) |=> (state_ff == fiht_pkg::ST_L_SRD))
      else $error("lookup key check not followed by next slot read");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fiht_pkg::ST_CLEAR) |-> !req_ready)
      else $error("request taken during clear pass");

endmodule

### hdl/fiht_dp.sv
// Datapath for the frame index hash table: key and slot memories, probe
// counters, group arithmetic and result registers. Depends on fiht_pkg.
`timescale 1ns / 1ps

module fiht_dp #(
   parameter int NUM_GROUPS      = 4,
   parameter int KEYS_PER_GROUP  = 4096,
   parameter int SLOTS_PER_GROUP = 8192,
   parameter int HEADER_WORDS    = 34
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fiht_pkg::cmd_type             cmd,
   output fiht_pkg::stat_type            stat,
   input  logic [1:0]                    req_op,
   input  logic [fiht_pkg::KEY_W-1:0]    req_page_key,
   input  logic [fiht_pkg::FRAME_W-1:0]  req_frame_number,
   input  logic [fiht_pkg::FRAME_W-1:0]  req_lower_bound,
   input  logic [fiht_pkg::FRAME_W-1:0]  req_last_frame,
   output logic                          rsp_status,
   output logic [fiht_pkg::FRAME_W-1:0]  rsp_found_frame,
   output logic [fiht_pkg::KEY_W-1:0]    rsp_found_key
);

   localparam int NKEYS  = NUM_GROUPS * KEYS_PER_GROUP;
   localparam int NSLOTS = NUM_GROUPS * SLOTS_PER_GROUP;
   localparam int KAW    = $clog2(NKEYS);
   localparam int SAW    = $clog2(NSLOTS);
   localparam int GAW    = $clog2(NUM_GROUPS + 1);
   localparam int HBW    = $clog2(SLOTS_PER_GROUP);
   localparam int SVW    = $clog2(KEYS_PER_GROUP + 1);
   localparam int LMAX   = (SLOTS_PER_GROUP > KEYS_PER_GROUP) ? SLOTS_PER_GROUP
                                                              : KEYS_PER_GROUP;
   localparam int LW     = $clog2(LMAX + 1);
   localparam int CLR_N  = (NSLOTS > NKEYS) ? NSLOTS : NKEYS;
   localparam int CCW    = $clog2(CLR_N);
   localparam int EW     = $clog2((NUM_GROUPS + 1) * KEYS_PER_GROUP + 16448);
   localparam int FW     = fiht_pkg::FRAME_W;
   localparam int KW     = fiht_pkg::KEY_W;

   // group of a frame, NUM_GROUPS when out of range
   function automatic logic [GAW-1:0] grp_of(input logic [FW-1:0] v);
      logic [EW-1:0]  x;
      logic [GAW-1:0] cnt;
      x   = EW'(v) + EW'(HEADER_WORDS) - EW'(1);
      cnt = '0;
      for (int i = 1; i <= NUM_GROUPS; i++) begin
         if (v != '0 && x >= EW'(i * KEYS_PER_GROUP)) cnt = cnt + GAW'(1);
      end
      return cnt;
   endfunction

   // key address of relative frame 1 of group g
   function automatic logic [EW-1:0] gofs(input logic [GAW-1:0] g);
      return EW'(g) * EW'(KEYS_PER_GROUP) + ((g == '0) ? EW'(HEADER_WORDS) : '0);
   endfunction

   function automatic logic [EW-1:0] gcap(input logic [GAW-1:0] g);
      return (g == '0) ? EW'(KEYS_PER_GROUP - HEADER_WORDS) : EW'(KEYS_PER_GROUP);
   endfunction

   logic [KW-1:0]  key_mem [NKEYS];
   logic [SVW-1:0] slot_mem [NSLOTS];

   logic [1:0]     op_ff;
   logic [KW-1:0]  key_ff;
   logic [FW-1:0]  frame_ff, lower_ff, maxf_ff;
   logic [GAW-1:0] ga_ff, ga_in;
   logic [CCW-1:0] cc_ff;
   logic [KAW-1:0] kc_ff, khi_ff;
   logic [GAW-1:0] sg_ff;
   logic [HBW-1:0] sc_ff;
   logic [GAW-1:0] n_ff;
   logic [HBW-1:0] h_ff;
   logic [LW-1:0]  left_ff;
   logic [SVW-1:0] rel_ff;
   logic           err_ff;
   logic [FW-1:0]  found_ff;
   logic [KW-1:0]  fkey_ff;
   logic           rsp_status_ff;
   logic [FW-1:0]  rsp_found_frame_ff;
   logic [KW-1:0]  rsp_found_key_ff;

   logic [KW-1:0]  key_rd_ff;
   logic [SVW-1:0] slot_rd_ff;

   logic [GAW-1:0] fgrp, mgrp, lgrp;
   logic [EW-1:0]  xf, xm, clean_lo, clean_hi, abs_l, kaddr_l;
   logic [SVW-1:0] rel_a;
   logic [KW-1:0]  hash_prod;
   logic [HBW-1:0] hash;
   logic           slot_gt, lk_match;

   logic           key_we, key_re;
   logic [KAW-1:0] key_wa, key_ra;
   logic [KW-1:0]  key_wd;
   logic           slot_we, slot_re;
   logic [SAW-1:0] slot_wa, slot_ra;
   logic [SVW-1:0] slot_wd;

   assign fgrp      = grp_of(frame_ff);
   assign mgrp      = grp_of(maxf_ff);
   assign lgrp      = grp_of(lower_ff);
   assign xf        = EW'(frame_ff) + EW'(HEADER_WORDS) - EW'(1);
   assign xm        = EW'(maxf_ff) + EW'(HEADER_WORDS) - EW'(1);
   assign clean_lo  = xm + EW'(1);
   assign clean_hi  = (EW'(mgrp) + EW'(1)) * EW'(KEYS_PER_GROUP) - EW'(1);
   assign rel_a     = SVW'(xf - gofs(fgrp) + EW'(1));
   assign hash_prod = key_ff * fiht_pkg::HASH_MULT;
   assign hash      = hash_prod[HBW-1:0];
   assign kaddr_l   = gofs(n_ff) + EW'(slot_rd_ff) - EW'(1);
   assign abs_l     = gofs(n_ff) + EW'(rel_ff) - EW'(HEADER_WORDS);
   assign slot_gt   = (slot_rd_ff != '0) && (gofs(sg_ff) + EW'(slot_rd_ff) - EW'(1) > xm);
   assign lk_match  = (abs_l >= EW'(lower_ff)) && (abs_l <= EW'(maxf_ff)) &&
                      (EW'(rel_ff) <= gcap(n_ff)) && (key_rd_ff == key_ff);

   always_comb begin
      stat.op               = op_ff;
      stat.clr_done         = (cc_ff == CCW'(CLR_N - 1));
      stat.frame_ok         = (frame_ff != '0) && (fgrp < GAW'(NUM_GROUPS));
      stat.frame_first      = (xf == gofs(fgrp));
      stat.fetch_ok         = stat.frame_ok && (fgrp < ga_ff);
      stat.key_nz           = (key_rd_ff != '0);
      stat.clean_ok         = (maxf_ff != '0) && (mgrp < GAW'(NUM_GROUPS));
      stat.clean_keys_empty = (clean_lo > clean_hi);
      stat.kdone            = (kc_ff == khi_ff);
      stat.sdone            = (sc_ff == HBW'(SLOTS_PER_GROUP - 1));
      stat.slot_zero        = (slot_rd_ff == '0);
      stat.left_zero        = (left_ff == '0);
      stat.maxf_zero        = (maxf_ff == '0);
      stat.grp_active       = (n_ff < ga_ff) && (n_ff < GAW'(NUM_GROUPS));
      stat.lk_stop          = (found_ff != '0) || (n_ff <= lgrp) || (n_ff == '0);
   end

   always_comb begin
      ga_in = ga_ff;
      if (cmd.alloc_frame && ga_ff < fgrp + GAW'(1)) ga_in = fgrp + GAW'(1);
      if (cmd.alloc_max && ga_ff < mgrp + GAW'(1)) ga_in = mgrp + GAW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ga_ff <= '0;
         cc_ff <= '0;
      end else begin
         ga_ff <= ga_in;
         if (cmd.clr_step && !stat.clr_done) cc_ff <= cc_ff + CCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         op_ff    <= req_op;
         key_ff   <= req_page_key;
         frame_ff <= req_frame_number;
         lower_ff <= req_lower_bound;
         maxf_ff  <= req_last_frame;
         err_ff   <= 1'b0;
         found_ff <= '0;
         fkey_ff  <= '0;
      end
      if (cmd.kinit_grp) begin
         kc_ff  <= KAW'(gofs(fgrp));
         khi_ff <= KAW'((EW'(fgrp) + EW'(1)) * EW'(KEYS_PER_GROUP) - EW'(1));
      end else if (cmd.kinit_clean) begin
         kc_ff  <= KAW'(clean_lo);
         khi_ff <= KAW'(clean_hi);
      end else if (cmd.k_step) begin
         kc_ff <= kc_ff + KAW'(1);
      end
      if (cmd.sinit_frame) begin
         sg_ff <= fgrp;
         sc_ff <= '0;
      end else if (cmd.sinit_max) begin
         sg_ff <= mgrp;
         sc_ff <= '0;
      end else if (cmd.s_step) begin
         sc_ff <= sc_ff + HBW'(1);
      end
      if (cmd.probe_init) begin
         n_ff    <= fgrp;
         h_ff    <= hash;
         left_ff <= LW'(rel_a);
      end else if (cmd.lk_init) begin
         n_ff <= mgrp;
      end else if (cmd.lk_grp_init) begin
         h_ff    <= hash;
         left_ff <= LW'(SLOTS_PER_GROUP);
      end else if (cmd.probe_adv) begin
         h_ff    <= h_ff + HBW'(1);
         left_ff <= left_ff - LW'(1);
      end else if (cmd.lk_hit_rd) begin
         rel_ff  <= slot_rd_ff;
         left_ff <= left_ff - LW'(1);
      end else if (cmd.lk_chk) begin
         h_ff <= h_ff + HBW'(1);
         if (lk_match) found_ff <= FW'(abs_l);
      end else if (cmd.lk_dec) begin
         n_ff <= n_ff - GAW'(1);
      end
      if (cmd.set_err) begin
         err_ff   <= 1'b1;
         found_ff <= '0;
      end
      if (cmd.fetch_latch) fkey_ff <= key_rd_ff;
      if (cmd.rsp_load) begin
         rsp_status_ff      <= err_ff;
         rsp_found_frame_ff <= found_ff;
         rsp_found_key_ff   <= fkey_ff;
      end
   end

   always_comb begin
      key_we = 1'b0;
      key_wa = KAW'(xf);
      key_wd = '0;
      if (cmd.clr_step) begin
         key_we = (EW'(cc_ff) < EW'(NKEYS));
         key_wa = KAW'(cc_ff);
      end else if (cmd.k_step) begin
         key_we = 1'b1;
         key_wa = kc_ff;
      end else if (cmd.assign_wr) begin
         key_we = 1'b1;
         key_wd = key_ff;
      end
      key_re = cmd.key_rd_frame || cmd.lk_hit_rd;
      key_ra = cmd.lk_hit_rd ? KAW'(kaddr_l) : KAW'(xf);
   end

   always_comb begin
      slot_we = 1'b0;
      slot_wa = SAW'({n_ff, h_ff});
      slot_wd = '0;
      if (cmd.clr_step) begin
         slot_we = (EW'(cc_ff) < EW'(NSLOTS));
         slot_wa = SAW'(cc_ff);
      end else if (cmd.s_clr_wr || (cmd.s_cond_wr && slot_gt)) begin
         slot_we = 1'b1;
         slot_wa = SAW'({sg_ff, sc_ff});
      end else if (cmd.assign_wr) begin
         slot_we = 1'b1;
         slot_wd = rel_a;
      end
      slot_re = cmd.s_rd || cmd.probe_rd;
      slot_ra = cmd.s_rd ? SAW'({sg_ff, sc_ff}) : SAW'({n_ff, h_ff});
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_wa] <= key_wd;
      if (key_re) key_rd_ff <= key_mem[key_ra];
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
      if (slot_re) slot_rd_ff <= slot_mem[slot_ra];
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_found_frame = rsp_found_frame_ff;
   assign rsp_found_key   = rsp_found_key_ff;

endmodule

### hdl/frame_index_hash_table.sv
// Frame index hash table: page key to log frame number, linear probing per group.
// Assign on the first frame of a group first clears that group's keys and slots;
// a cleanup clears the keys after the last frame and scans the slots of its group.
// Lookup searches the allocated groups from the last frame's group downward.
// Rejected requests go straight to the response. One request at a time.
// After reset a clearing pass runs over both memories.
`timescale 1ns / 1ps

module frame_index_hash_table #(
   parameter int NUM_GROUPS      = 4,
   parameter int KEYS_PER_GROUP  = 4096,
   parameter int SLOTS_PER_GROUP = 8192,
   parameter int HEADER_WORDS    = 34
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_op,
   input  logic [fiht_pkg::KEY_W-1:0]   req_page_key,
   input  logic [fiht_pkg::FRAME_W-1:0] req_frame_number,
   input  logic [fiht_pkg::FRAME_W-1:0] req_lower_bound,
   input  logic [fiht_pkg::FRAME_W-1:0] req_last_frame,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_status,
   output logic [fiht_pkg::FRAME_W-1:0] rsp_found_frame,
   output logic [fiht_pkg::KEY_W-1:0]   rsp_found_key
);

   fiht_pkg::cmd_type  cmd;
   fiht_pkg::stat_type stat;

   fiht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   fiht_dp #(
      .NUM_GROUPS      (NUM_GROUPS),
      .KEYS_PER_GROUP  (KEYS_PER_GROUP),
      .SLOTS_PER_GROUP (SLOTS_PER_GROUP),
      .HEADER_WORDS    (HEADER_WORDS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_op),
      .req_page_key     (req_page_key),
      .req_frame_number (req_frame_number),
      .req_lower_bound  (req_lower_bound),
      .req_last_frame   (req_last_frame),
      .rsp_status       (rsp_status),
      .rsp_found_frame  (rsp_found_frame),
      .rsp_found_key    (rsp_found_key)
   );

endmodule

### test/frame_index_hash_table_tb.sv
// Testbench for frame_index_hash_table: directed table, then random log-style traffic
// checked against a behavioral predictor. Depends on hdl/fiht_pkg.sv and the RTL.
`timescale 1ns / 1ps

module frame_index_hash_table_tb;

   localparam logic [1:0] OP_NONE = 2'd3;
   localparam int GROUPS   = 4;
   localparam int KEYS     = 4096;
   localparam int SLOTS    = 8192;
   localparam int HDR      = 34;
   localparam int N_RANDOM = 1250;

   typedef struct {
      logic                          status;
      logic [fiht_pkg::FRAME_W-1:0]  frame;
      logic [fiht_pkg::KEY_W-1:0]    key;
   } answer_type;

   typedef struct {
      logic [1:0]                    op;
      logic [fiht_pkg::KEY_W-1:0]    key;
      logic [fiht_pkg::FRAME_W-1:0]  frame;
      logic [fiht_pkg::FRAME_W-1:0]  lower;
      logic [fiht_pkg::FRAME_W-1:0]  maxf;
      bit                            typed;
      answer_type                    ans;
   } row_type;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic [1:0]                   req_op;
   logic [fiht_pkg::KEY_W-1:0]   req_page_key;
   logic [fiht_pkg::FRAME_W-1:0] req_frame_number, req_lower_bound, req_last_frame;
   logic                         rsp_status;
   logic [fiht_pkg::FRAME_W-1:0] rsp_found_frame;
   logic [fiht_pkg::KEY_W-1:0]   rsp_found_key;

   frame_index_hash_table DUT (.*);

   // predictor state
   bit [31:0] key_mem [0:GROUPS*KEYS-1];
   bit [15:0] slot_mem [0:GROUPS*SLOTS-1];
   int unsigned groups_used;

   answer_type answers_due[$];
   int errors, n_rsp, n_hits, n_collide, n_assign;
   int tx_idle, rx_stall;
   bit hold_req;

   function automatic int unsigned grp_of(int unsigned v);
      return v == 0 ? 0 : (v - 1 + HDR) / KEYS;
   endfunction

   function automatic int unsigned grp_base(int unsigned n);
      return n != 0 ? (KEYS - HDR) + KEYS * (n - 1) : 0;
   endfunction

   function automatic int unsigned grp_cap(int unsigned n);
      return n != 0 ? KEYS : KEYS - HDR;
   endfunction

   function automatic int unsigned key_addr(int unsigned n, int unsigned rel);
      return n * KEYS + (n != 0 ? 0 : HDR) + rel - 1;
   endfunction

   function automatic int unsigned hash_of(bit [31:0] k);
      bit [31:0] p;
      p = k * 32'd383;
      return p & (SLOTS - 1);
   endfunction

   function automatic void mark_group(int unsigned n);
      if (groups_used < n + 1) groups_used = n + 1;
   endfunction

   function automatic answer_type store_key(bit [31:0] k, int unsigned v, int unsigned mx);
      answer_type r;
      int unsigned n, rel, cap, h, left, g, limit;
      r = '{0, 0, 0};
      n = grp_of(v);
      if (v == 0 || n >= GROUPS) return r;
      mark_group(n);
      rel = v - grp_base(n);
      cap = grp_cap(n);
      if (rel == 0 || rel > cap) return r;
      if (rel == 1) begin
         for (int i = 0; i < cap; i++) key_mem[key_addr(n, 1) + i] = 0;
         for (int i = 0; i < SLOTS; i++) slot_mem[n * SLOTS + i] = 0;
      end
      if (key_mem[key_addr(n, rel)] != 0 && mx != 0) begin
         g = grp_of(mx);
         if (g < GROUPS) begin
            mark_group(g);
            limit = mx - grp_base(g);
            for (int i = 0; i < SLOTS; i++)
               if (slot_mem[g * SLOTS + i] > limit) slot_mem[g * SLOTS + i] = 0;
            for (int unsigned i = limit + 1; i <= grp_cap(g); i++) key_mem[key_addr(g, i)] = 0;
         end
      end
      h = hash_of(k);
      left = rel;
      while (slot_mem[n * SLOTS + h] != 0) begin
         if (left == 0) begin
            r.status = 1'b1;
            return r;
         end
         left--;
         h = (h + 1) & (SLOTS - 1);
      end
      slot_mem[n * SLOTS + h] = 16'(rel);
      key_mem[key_addr(n, rel)] = k;
      return r;
   endfunction

   function automatic answer_type find_frame(bit [31:0] k, int unsigned lo, int unsigned mx);
      answer_type r;
      int unsigned n, min_g, found, h, left, rel, ab;
      r = '{0, 0, 0};
      found = 0;
      if (mx == 0) return r;
      min_g = grp_of(lo);
      n = grp_of(mx);
      forever begin
         if (n < groups_used && n < GROUPS) begin
            h = hash_of(k);
            left = SLOTS;
            while (slot_mem[n * SLOTS + h] != 0) begin
               rel = slot_mem[n * SLOTS + h];
               if (left == 0) begin
                  r.status = 1'b1;
                  return r;
               end
               left--;
               ab = rel + grp_base(n);
               if (ab >= lo && ab <= mx && rel <= grp_cap(n) &&
                   key_mem[key_addr(n, rel)] == k) found = ab;
               h = (h + 1) & (SLOTS - 1);
            end
         end
         if (found != 0 || n <= min_g || n == 0) break;
         n--;
      end
      r.frame = found[fiht_pkg::FRAME_W-1:0];
      return r;
   endfunction

   function automatic answer_type frame_key(int unsigned v);
      answer_type r;
      int unsigned n, rel;
      r = '{0, 0, 0};
      n = grp_of(v);
      if (v == 0 || n >= groups_used || n >= GROUPS) return r;
      rel = v - grp_base(n);
      if (rel == 0 || rel > grp_cap(n)) return r;
      r.key = key_mem[key_addr(n, rel)];
      return r;
   endfunction

   function automatic answer_type predict(row_type q);
      answer_type r;
      r = '{0, 0, 0};
      case (q.op)
         fiht_pkg::OP_ASSIGN: begin
            r = store_key(q.key, 32'(q.frame), 32'(q.maxf));
            n_assign++;
            if (r.status) n_collide++;
         end
         fiht_pkg::OP_LOOKUP: begin
            r = find_frame(q.key, 32'(q.lower), 32'(q.maxf));
            if (r.frame != 0) n_hits++;
         end
         fiht_pkg::OP_FETCH: r = frame_key(32'(q.frame));
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_req(row_type q);
      answer_type r;
      if ($urandom_range(99) < tx_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= q.op;
      req_page_key     <= q.key;
      req_frame_number <= q.frame;
      req_lower_bound  <= q.lower;
      req_last_frame   <= q.maxf;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      r = predict(q);
      answers_due.push_back(q.typed ? q.ans : r);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("Some tests failed");
      $finish;
   end

   // receiver
   always @(posedge clock) begin
      int hold;
      if (hold_req) begin
         hold_req = 0;
         hold = 300;
      end
      if (hold > 0) begin
         hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= rx_stall;
      end
   end

   always @(negedge clock) begin
      answer_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         n_rsp++;
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected response status=%0d frame=%0d key=%h", $time,
                     rsp_status, rsp_found_frame, rsp_found_key);
            errors++;
         end else begin
            e = answers_due.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_found_frame !== e.frame) begin
               $display("%0t: found_frame expected %0d actual %0d", $time, e.frame,
                        rsp_found_frame);
               errors++;
            end
            if (rsp_found_key !== e.key) begin
               $display("%0t: found_key expected %h actual %h", $time, e.key, rsp_found_key);
               errors++;
            end
         end
      end
   end

   initial begin
      row_type rows[$];
      row_type q;
      bit [31:0] pool[16];
      int unsigned head, r, b;

      reset = 1'b1;
      req_valid = 1'b0;
      req_op = fiht_pkg::OP_FETCH;
      req_page_key = '0;
      req_frame_number = '0;
      req_lower_bound = '0;
      req_last_frame = '0;
      rsp_ready = 1'b0;
      hold_req = 0;
      tx_idle = 0;
      rx_stall = 0;
      groups_used = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // op, key, frame, lower, last_frame, typed, {status, frame, key}
      rows = '{
         '{fiht_pkg::OP_FETCH,  32'h0,        14'd0,     14'd0,     14'd0,     1, '{0, 0, 0}},
         '{fiht_pkg::OP_LOOKUP, 32'h1234,     14'd0,     14'd0,     14'd0,     1, '{0, 0, 0}},
         '{fiht_pkg::OP_FETCH,  32'h0,        14'd16383, 14'd0,     14'd0,     1, '{0, 0, 0}},
         '{fiht_pkg::OP_ASSIGN, 32'hFFFFFFFF, 14'd1,     14'd0,     14'd1,     1, '{0, 0, 0}},
         '{fiht_pkg::OP_ASSIGN, 32'hFFFFDFFF, 14'd2,     14'd0,     14'd1,     0, '{0, 0, 0}},
         '{fiht_pkg::OP_ASSIGN, 32'h00000001, 14'd3,     14'd0,     14'd2,     0, '{0, 0, 0}},
         '{fiht_pkg::OP_LOOKUP, 32'hFFFFFFFF, 14'd0,     14'd0,     14'd3,     0, '{0, 0, 0}},
         '{fiht_pkg::OP_FETCH,  32'h0,        14'd1,     14'd0,     14'd3,     0, '{0, 0, 0}},
         '{fiht_pkg::OP_ASSIGN, 32'h55555555, 14'd0,     14'd0,     14'd3,     1, '{0, 0, 0}},
         '{fiht_pkg::OP_ASSIGN, 32'hAAAAAAAA, 14'd16383, 14'd16383, 14'd16383, 1, '{0, 0, 0}},
         '{fiht_pkg::OP_ASSIGN, 32'h5,        14'd4062,  14'd0,     14'd4061,  0, '{0, 0, 0}},
         '{fiht_pkg::OP_ASSIGN, 32'h7,        14'd4063,  14'd0,     14'd4062,  0, '{0, 0, 0}},
         '{fiht_pkg::OP_LOOKUP, 32'h5,        14'd0,     14'd4063,  14'd4063,  0, '{0, 0, 0}},
         '{fiht_pkg::OP_LOOKUP, 32'h5,        14'd0,     14'd1,     14'd4063,  0, '{0, 0, 0}},
         '{fiht_pkg::OP_LOOKUP, 32'h7,        14'd0,     14'd0,     14'd4063,  0, '{0, 0, 0}},
         '{OP_NONE,             32'hFFFFFFFF, 14'd16383, 14'd16383, 14'd16383, 1, '{0, 0, 0}},
         '{fiht_pkg::OP_ASSIGN, 32'h00001FFF, 14'd2,     14'd0,     14'd3,     0, '{0, 0, 0}},
         '{fiht_pkg::OP_ASSIGN, 32'hFFFFFFFF, 14'd1,     14'd0,     14'd3,     0, '{0, 0, 0}},
         '{fiht_pkg::OP_LOOKUP, 32'h1,        14'd0,     14'd16383, 14'd16383, 1, '{0, 0, 0}},
         '{fiht_pkg::OP_FETCH,  32'h0,        14'd4062,  14'd0,     14'd3,     0, '{0, 0, 0}},
         '{fiht_pkg::OP_FETCH,  32'h0,        14'd2,     14'd0,     14'd3,     0, '{0, 0, 0}},
         '{fiht_pkg::OP_LOOKUP, 32'h0,        14'd0,     14'd0,     14'd16383, 0, '{0, 0, 0}}
      };
      foreach (rows[i]) send_req(rows[i]);

      for (int i = 0; i < 16; i++)
         pool[i] = i < 8 ? $urandom() : pool[i - 8] + 32'd8192 * $urandom_range(1, 3);
      head = 3;
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 250) tx_idle = 56;
         if (i == 400) hold_req = 1;
         if (i == 550) begin
            tx_idle = 0;
            rx_stall = 56;
         end
         if (i == 700) begin
            req_valid <= 1'b0;
            while (answers_due.size() != 0) @(posedge clock);
         end
         if (i == 850) begin
            tx_idle = 31;
            rx_stall = 31;
         end
         r = $urandom_range(999);
         q.typed = 0;
         q.ans = '{0, 0, 0};
         q.lower = '0;
         if (r < 430) begin
            if (head >= 16383) head = 0;
            q.op = fiht_pkg::OP_ASSIGN;
            q.key = $urandom_range(9) < 7 ? pool[$urandom_range(15)] : $urandom();
            q.frame = 14'(head + 1);
            q.maxf = 14'($urandom_range(3) != 0 ? head : head + 1);
            head++;
         end else if (r < 730) begin
            q.op = fiht_pkg::OP_LOOKUP;
            q.key = $urandom_range(9) < 8 ? pool[$urandom_range(15)] : $urandom();
            q.frame = 14'($urandom());
            q.lower = 14'($urandom_range(head));
            q.maxf = 14'(head);
         end else if (r < 860) begin
            q.op = fiht_pkg::OP_FETCH;
            q.key = $urandom();
            q.frame = 14'($urandom_range(head < 16381 ? head + 2 : 16383));
            q.maxf = 14'(head);
         end else if (r < 885) begin
            if (r < 880) begin
               b = $urandom_range(5);
               case (b)
                  0: head = 4060;
                  1: head = 8156;
                  2: head = 12252;
                  3: head = 16348;
                  4: head = 16383;
                  default: head = $urandom_range(16383);
               endcase
            end else if (head > 5) begin
               head = head - $urandom_range(1, 5);
            end
            continue;
         end else begin
            q.op = 2'($urandom());
            q.key = $urandom();
            q.frame = 14'($urandom());
            q.lower = 14'($urandom());
            q.maxf = 14'($urandom());
         end
         send_req(q);
      end
      req_valid <= 1'b0;

      while (answers_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d responses: %0d assigns (%0d probe overflows), %0d lookup hits,",
               n_rsp, n_assign, n_collide, n_hits);
      $display("group clears, cleanups, out-of-range frames and unknown ops under random stalls.");
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### sim.f
hdl/fiht_pkg.sv
hdl/fiht_ctrl.sv
hdl/fiht_dp.sv
hdl/frame_index_hash_table.sv
test/frame_index_hash_table_tb.sv
